// ===== rtl/core/psqm_pkg.sv =====
// Types, codes and helpers shared by the priority staging queue.
// No dependencies.
package psqm_pkg;

	localparam int LEVELS = 3;
	localparam int LVL_W = 2;

	localparam logic [1:0] LVL_HIGH = 2'd0;
	localparam logic [1:0] LVL_NORMAL = 2'd1;
	localparam logic [1:0] LVL_LOW = 2'd2;

	localparam logic OP_POST = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [2:0] K_ACCEPTED = 3'd0;
	localparam logic [2:0] K_OVERFLOW = 3'd1;
	localparam logic [2:0] K_DELIVERED = 3'd2;
	localparam logic [2:0] K_MERGED = 3'd3;
	localparam logic [2:0] K_EMPTY = 3'd4;
	localparam logic [2:0] K_DISABLED = 3'd5;

	localparam logic [2:0] R_ENABLED = 3'd0;
	localparam logic [2:0] R_MODE = 3'd1;
	localparam logic [2:0] R_CRIT_MASK = 3'd2;
	localparam logic [2:0] R_MERGE_MASK = 3'd3;
	localparam logic [2:0] R_HIGH_TH = 3'd4;
	localparam logic [2:0] R_NORMAL_TH = 3'd5;

	localparam logic [15:0] SAT16 = 16'hFFFF;

	typedef struct packed {
		logic        operation;
		logic [15:0] event_handle;
		logic [7:0]  target_id;
		logic [15:0] signal;
		logic [7:0]  flags;
		logic [7:0]  priority_req;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] event_handle_res;
		logic [7:0]  target_id_res;
		logic [15:0] signal_res;
		logic [1:0]  level;
		logic        last;
		logic [15:0] lost_total;
		logic [15:0] merged_total;
	} out_t;

	typedef struct packed {
		logic        mergeable;
		logic [15:0] signal;
		logic [7:0]  target;
		logic [15:0] handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic can_merge(input entry_t a, input entry_t b, input logic mode);
		logic same;
		same = (a.target == b.target) && (a.signal == b.signal);
		if (!mode)
			return same;
		return same && (a.signal != 16'd0) && a.mergeable && b.mergeable;
	endfunction

endpackage

// ===== rtl/core/psqm_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module psqm_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/priority_staging_queue_with_merge.sv =====
// Three-level staging queue with merge detection on dispatch.
// Depends on psqm_pkg and psqm_ram.
//
// channel   direction  handshake        word
// cmd       in         start / busy     psqm_pkg::in_t
// res       out        done (strobe)    psqm_pkg::out_t
// config    in         wr_en            wr_idx, wr_data
//
// A post leaves busy low; its word appears on res the next cycle and a new
// command may start in that cycle. A dispatch visits each level in turn (empty
// levels ahead of the last staged one included); in a level it reads each
// staged entry, then reads and compares each later entry against it; a merge
// hit ends that entry's scan early. A dispatch that finds staged entries keeps
// busy high throughout. Reset clears indices and counters, not ring contents.
// The receiver cannot stall: every word is shown for exactly one cycle.
module priority_staging_queue_with_merge #(
	parameter int RING_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  psqm_pkg::in_t  cmd,
	output logic           done,
	output psqm_pkg::out_t res,
	input  logic           wr_en,
	input  logic [2:0]     wr_idx,
	input  logic [7:0]     wr_data
);
	import psqm_pkg::*;

	localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int MEM_DEPTH = LEVELS * RING_DEPTH;
	localparam int AW = $clog2(MEM_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LVL = 3'd1;
	localparam logic [2:0] S_RDI = 3'd2;
	localparam logic [2:0] S_GETI = 3'd3;
	localparam logic [2:0] S_RDJ = 3'd4;
	localparam logic [2:0] S_CMPJ = 3'd5;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] x);
		return (x == IW'(RING_DEPTH - 1)) ? '0 : x + IW'(1);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [1:0] l, input logic [IW-1:0] x);
		return AW'(l) * AW'(RING_DEPTH) + AW'(x);
	endfunction

	logic        enabled_q, mode_q;
	logic [7:0]  crit_q, mmask_q, hth_q, nth_q;
	logic [2:0]  state_q;
	logic [1:0]  lvl_q;
	logic [IW-1:0] head_q [LEVELS];
	logic [IW-1:0] tail_q [LEVELS];
	logic [IW-1:0] i_q, j_q;
	logic [15:0] ovf_q [LEVELS];
	logic [15:0] merge_q;
	entry_t      e_q;

	logic        done_q;
	logic [2:0]  kind_q;
	logic [15:0] hnd_q, sig_q;
	logic [7:0]  tgt_q;
	logic [1:0]  rlvl_q;
	logic        last_q;

	logic        post_acc, disp_acc, any_staged;
	logic [1:0]  lvl_c;
	logic        full_c, we;
	logic [AW-1:0] waddr, raddr;
	entry_t      wentry, ent_rd;
	logic [ENTRY_W-1:0] rdata;
	logic        merge_hit, emit, emit_m, later_busy, lvl_done;
	entry_t      emit_ent;
	logic [IW-1:0] i_adv, jn_geti, jn_cmp;
	logic [17:0] lost_sum;

	assign busy = (state_q != S_IDLE);
	assign post_acc = start && !busy && (cmd.operation == OP_POST);
	assign disp_acc = start && !busy && (cmd.operation == OP_DISPATCH);

	always_comb begin
		if (!mode_q || cmd.signal == 16'd0)
			lvl_c = LVL_NORMAL;
		else if ((cmd.flags & crit_q) != 8'd0)
			lvl_c = LVL_HIGH;
		else if (cmd.priority_req > hth_q)
			lvl_c = LVL_HIGH;
		else if (cmd.priority_req > nth_q)
			lvl_c = LVL_NORMAL;
		else
			lvl_c = LVL_LOW;
	end

	always_comb begin
		full_c = (lvl_c != 2'd3) && (nxt(tail_q[lvl_c]) == head_q[lvl_c]);
		we = post_acc && enabled_q && !full_c;
		waddr = addr_of(lvl_c, tail_q[lvl_c]);
		wentry.mergeable = (cmd.flags & mmask_q) != 8'd0;
		wentry.signal = cmd.signal;
		wentry.target = cmd.target_id;
		wentry.handle = cmd.event_handle;
		raddr = addr_of(lvl_q, (state_q == S_RDJ) ? j_q : i_q);
	end

	psqm_ram #(.WIDTH(ENTRY_W), .DEPTH(MEM_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wentry),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		ent_rd = entry_t'(rdata);
		jn_geti = nxt(i_q);
		jn_cmp = nxt(j_q);
		i_adv = nxt(i_q);
		merge_hit = can_merge(e_q, ent_rd, mode_q);
		emit = ((state_q == S_GETI) && (jn_geti == tail_q[lvl_q])) ||
		       ((state_q == S_CMPJ) && (merge_hit || jn_cmp == tail_q[lvl_q]));
		emit_m = (state_q == S_CMPJ) && merge_hit;
		emit_ent = (state_q == S_GETI) ? ent_rd : e_q;
		lvl_done = (i_adv == tail_q[lvl_q]);
		later_busy = 1'b0;
		any_staged = 1'b0;
		for (int k = 0; k < LEVELS; k++) begin
			if (head_q[k] != tail_q[k]) begin
				any_staged = 1'b1;
				if (LVL_W'(k) > lvl_q)
					later_busy = 1'b1;
			end
		end
		lost_sum = 18'(ovf_q[0]) + 18'(ovf_q[1]) + 18'(ovf_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			mode_q <= 1'b0;
			crit_q <= 8'd1;
			mmask_q <= 8'd2;
			hth_q <= 8'd128;
			nth_q <= 8'd64;
		end else if (wr_en) begin
			case (wr_idx)
				R_ENABLED: enabled_q <= wr_data[0];
				R_MODE: mode_q <= wr_data[0];
				R_CRIT_MASK: crit_q <= wr_data;
				R_MERGE_MASK: mmask_q <= wr_data;
				R_HIGH_TH: hth_q <= wr_data;
				R_NORMAL_TH: nth_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lvl_q <= '0;
			i_q <= '0;
			j_q <= '0;
			merge_q <= '0;
			done_q <= 1'b0;
			for (int k = 0; k < LEVELS; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				ovf_q[k] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (post_acc) begin
						done_q <= 1'b1;
						if (!enabled_q) begin
							;
						end else if (full_c) begin
							if (ovf_q[lvl_c] != SAT16)
								ovf_q[lvl_c] <= ovf_q[lvl_c] + 16'd1;
						end else begin
							tail_q[lvl_c] <= nxt(tail_q[lvl_c]);
						end
					end else if (disp_acc) begin
						if (!any_staged)
							done_q <= 1'b1;
						else begin
							lvl_q <= LVL_HIGH;
							state_q <= S_LVL;
						end
					end
				end
				S_LVL: begin
					if (lvl_q == 2'd3)
						state_q <= S_IDLE;
					else if (head_q[lvl_q] == tail_q[lvl_q])
						lvl_q <= lvl_q + 2'd1;
					else begin
						i_q <= head_q[lvl_q];
						state_q <= S_RDI;
					end
				end
				S_RDI: state_q <= S_GETI;
				S_GETI: begin
					e_q <= ent_rd;
					j_q <= jn_geti;
					if (!emit)
						state_q <= S_RDJ;
				end
				S_RDJ: state_q <= S_CMPJ;
				S_CMPJ: begin
					if (!emit) begin
						j_q <= jn_cmp;
						state_q <= S_RDJ;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// advance to the next entry, or close the level
			if (emit) begin
				done_q <= 1'b1;
				if (emit_m && merge_q != SAT16)
					merge_q <= merge_q + 16'd1;
				i_q <= i_adv;
				if (lvl_done) begin
					head_q[lvl_q] <= tail_q[lvl_q];
					lvl_q <= lvl_q + 2'd1;
					state_q <= later_busy ? S_LVL : S_IDLE;
				end else begin
					state_q <= S_RDI;
				end
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (post_acc) begin
			hnd_q <= cmd.event_handle;
			tgt_q <= cmd.target_id;
			sig_q <= cmd.signal;
			last_q <= 1'b1;
			if (!enabled_q) begin
				kind_q <= K_DISABLED;
				rlvl_q <= LVL_HIGH;
			end else begin
				kind_q <= full_c ? K_OVERFLOW : K_ACCEPTED;
				rlvl_q <= lvl_c;
			end
		end else if (disp_acc) begin
			kind_q <= K_EMPTY;
			hnd_q <= '0;
			tgt_q <= '0;
			sig_q <= '0;
			rlvl_q <= LVL_HIGH;
			last_q <= 1'b1;
		end else if (emit) begin
			kind_q <= emit_m ? K_MERGED : K_DELIVERED;
			hnd_q <= emit_ent.handle;
			tgt_q <= emit_ent.target;
			sig_q <= emit_ent.signal;
			rlvl_q <= lvl_q;
			last_q <= lvl_done && !later_busy;
		end
	end

	assign done = done_q;
	always_comb begin
		res.kind = kind_q;
		res.event_handle_res = hnd_q;
		res.target_id_res = tgt_q;
		res.signal_res = sig_q;
		res.level = rlvl_q;
		res.last = last_q;
		res.lost_total = (lost_sum > 18'(SAT16)) ? SAT16 : lost_sum[15:0];
		res.merged_total = merge_q;
	end

	a_post_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		post_acc |=> done && res.last && !busy)
		else $error("post did not give a single final word");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (head_q[0] == tail_q[0]) && (head_q[1] == tail_q[1]) &&
			(head_q[2] == tail_q[2]))
		else $error("dispatch ended with staged entries");

	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.level != 2'd3)
		else $error("invalid level on result");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.last && (res.kind == K_DELIVERED || res.kind == K_MERGED) |-> !busy)
		else $error("final dispatch word while still busy");
endmodule

// ===== verif/priority_staging_queue_with_merge_check.sv =====
// Checker for the priority staging queue: mirrors the configuration and the
// three level rings, predicts every result word and compares it. Uses psqm_pkg.
`timescale 1ns / 1ps

module priority_staging_queue_with_merge_check #(
	parameter int RING_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  psqm_pkg::in_t  cmd,
	input  logic           done,
	input  psqm_pkg::out_t res,
	input  logic           wr_en,
	input  logic [2:0]     wr_idx,
	input  logic [7:0]     wr_data,
	output int             fail_count,
	output int             pending
);
	import psqm_pkg::*;

	entry_t ring [LEVELS][RING_DEPTH];
	int head [LEVELS];
	int tail [LEVELS];
	int lost [LEVELS];
	int merges;
	logic en_q, mode_q;
	logic [7:0] crit_q, mrg_q, hi_q, nm_q;
	out_t expected_words [$];

	function automatic int lost_sum();
		int s;
		s = lost[0] + lost[1] + lost[2];
		return s > 65535 ? 65535 : s;
	endfunction

	function automatic logic [1:0] pick_level(in_t c);
		if (!mode_q || c.signal == 16'd0)
			return LVL_NORMAL;
		if ((c.flags & crit_q) != 8'd0)
			return LVL_HIGH;
		if (c.priority_req > hi_q)
			return LVL_HIGH;
		if (c.priority_req > nm_q)
			return LVL_NORMAL;
		return LVL_LOW;
	endfunction

	function automatic logic pair_merges(entry_t a, entry_t b);
		if (a.target != b.target || a.signal != b.signal)
			return 1'b0;
		if (!mode_q)
			return 1'b1;
		return a.signal != 16'd0 && a.mergeable && b.mergeable;
	endfunction

	task automatic push_word(logic [2:0] k, logic [15:0] h, logic [7:0] t, logic [15:0] s,
			logic [1:0] l);
		out_t w;
		w.kind = k;
		w.event_handle_res = h;
		w.target_id_res = t;
		w.signal_res = s;
		w.level = l;
		w.last = 1'b0;
		w.lost_total = 16'(lost_sum());
		w.merged_total = 16'(merges);
		expected_words.push_back(w);
	endtask

	task automatic predict_command(in_t c);
		logic [1:0] l;
		int nx, n0, cnt;
		logic m;
		entry_t batch [RING_DEPTH];
		n0 = expected_words.size();
		if (c.operation == OP_POST) begin
			if (!en_q) begin
				push_word(K_DISABLED, c.event_handle, c.target_id, c.signal, LVL_HIGH);
			end else begin
				l = pick_level(c);
				nx = (tail[l] + 1) % RING_DEPTH;
				if (nx == head[l]) begin
					if (lost[l] < 65535)
						lost[l]++;
					push_word(K_OVERFLOW, c.event_handle, c.target_id, c.signal, l);
				end else begin
					ring[l][tail[l]] = '{mergeable: (c.flags & mrg_q) != 8'd0,
						signal: c.signal, target: c.target_id, handle: c.event_handle};
					tail[l] = nx;
					push_word(K_ACCEPTED, c.event_handle, c.target_id, c.signal, l);
				end
			end
		end else begin
			for (int lv = 0; lv < LEVELS; lv++) begin
				cnt = 0;
				while (head[lv] != tail[lv]) begin
					batch[cnt] = ring[lv][head[lv]];
					cnt++;
					head[lv] = (head[lv] + 1) % RING_DEPTH;
				end
				for (int i = 0; i < cnt; i++) begin
					m = 1'b0;
					for (int j = i + 1; j < cnt; j++)
						if (pair_merges(batch[i], batch[j]))
							m = 1'b1;
					if (m && merges < 65535)
						merges++;
					push_word(m ? K_MERGED : K_DELIVERED, batch[i].handle, batch[i].target,
						batch[i].signal, 2'(lv));
				end
			end
			if (expected_words.size() == n0)
				push_word(K_EMPTY, '0, '0, '0, LVL_HIGH);
		end
		expected_words[expected_words.size() - 1].last = 1'b1;
	endtask

	task automatic compare_word(out_t got);
		out_t w;
		if (expected_words.size() == 0) begin
			$error("unexpected result word kind %0d", got.kind);
			fail_count++;
			return;
		end
		w = expected_words.pop_front();
		if (got.kind !== w.kind) begin
			$error("kind: expected %0d, got %0d", w.kind, got.kind); fail_count++;
		end
		if (got.event_handle_res !== w.event_handle_res) begin
			$error("event_handle_res: expected %0h, got %0h", w.event_handle_res,
				got.event_handle_res); fail_count++;
		end
		if (got.target_id_res !== w.target_id_res) begin
			$error("target_id_res: expected %0h, got %0h", w.target_id_res, got.target_id_res);
			fail_count++;
		end
		if (got.signal_res !== w.signal_res) begin
			$error("signal_res: expected %0h, got %0h", w.signal_res, got.signal_res);
			fail_count++;
		end
		if (got.level !== w.level) begin
			$error("level: expected %0d, got %0d", w.level, got.level); fail_count++;
		end
		if (got.last !== w.last) begin
			$error("last: expected %0d, got %0d", w.last, got.last); fail_count++;
		end
		if (got.lost_total !== w.lost_total) begin
			$error("lost_total: expected %0d, got %0d", w.lost_total, got.lost_total);
			fail_count++;
		end
		if (got.merged_total !== w.merged_total) begin
			$error("merged_total: expected %0d, got %0d", w.merged_total, got.merged_total);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head[i] = 0;
				tail[i] = 0;
				lost[i] = 0;
			end
			merges = 0;
			fail_count = 0;
			en_q = 1'b1;
			mode_q = 1'b0;
			crit_q = 8'd1;
			mrg_q = 8'd2;
			hi_q = 8'd128;
			nm_q = 8'd64;
			expected_words.delete();
		end else begin
			// results first: they belong to commands already taken
			if (done)
				compare_word(res);
			if (wr_en) begin
				case (wr_idx)
					R_ENABLED: en_q = wr_data[0];
					R_MODE: mode_q = wr_data[0];
					R_CRIT_MASK: crit_q = wr_data;
					R_MERGE_MASK: mrg_q = wr_data;
					R_HIGH_TH: hi_q = wr_data;
					R_NORMAL_TH: nm_q = wr_data;
					default: ;
				endcase
			end
			if (start && !busy)
				predict_command(cmd);
		end
		pending = expected_words.size();
	end

endmodule

// ===== verif/priority_staging_queue_with_merge_test.sv =====
// Stimulus and verdict for the priority staging queue: directed and random
// posts and dispatches across register settings. Uses psqm_pkg and the checker.
`timescale 1ns / 1ps

module priority_staging_queue_with_merge_test;
	import psqm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t cmd = '0;
	logic done;
	out_t res;
	logic wr_en = 1'b0;
	logic [2:0] wr_idx = '0;
	logic [7:0] wr_data = '0;
	int fail_count;
	int pending;
	logic [7:0] tgt_pool [4];
	logic [15:0] sig_pool [4];

	always #5 clk = ~clk;

	priority_staging_queue_with_merge uut (.*);
	priority_staging_queue_with_merge_check chk (.*);

	// wait until the block is idle, hold the command for one edge, then drop start
	task automatic issue(in_t c);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		cmd <= c;
		start <= 1'b1;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic post(logic [15:0] h, logic [7:0] t, logic [15:0] s, logic [7:0] f,
			logic [7:0] p);
		issue('{operation: OP_POST, event_handle: h, target_id: t, signal: s, flags: f,
			priority_req: p});
	endtask

	task automatic dispatch_all();
		in_t c;
		c = $bits(in_t)'({$urandom, $urandom});
		c.operation = OP_DISPATCH;
		issue(c);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_post();
		logic [7:0] f;
		f = 8'($urandom);
		post(16'($urandom),
			($urandom_range(0, 3) != 0) ? tgt_pool[$urandom_range(0, 3)] : 8'($urandom),
			($urandom_range(0, 3) != 0) ? sig_pool[$urandom_range(0, 3)] : 16'($urandom),
			f, 8'($urandom));
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 30)
				repeat ($urandom_range(1, 6)) @(negedge clk);
			if ($urandom_range(0, 9) == 0)
				dispatch_all();
			else
				random_post();
		end
		dispatch_all();
	endtask

	initial begin
		tgt_pool = '{8'h00, 8'hFF, 8'h12, 8'h12};
		sig_pool = '{16'h0000, 16'hFFFF, 16'h0042, 16'h0007};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty dispatch, extremes, merge, full ring and overflow
		dispatch_all();
		post(16'h0000, 8'h00, 16'h0000, 8'h00, 8'h00);
		post(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
		post(16'h1234, 8'hFF, 16'hFFFF, 8'h00, 8'h40);
		dispatch_all();
		for (int i = 0; i < 17; i++)
			post(16'(i), 8'h05, 16'h0003, 8'h02, 8'(i));
		dispatch_all();

		write_reg(R_MODE, 8'd1);
		post(16'hA001, 8'h01, 16'h0000, 8'h03, 8'hFF);
		post(16'hA002, 8'h01, 16'h0009, 8'h01, 8'h00);
		post(16'hA003, 8'h01, 16'h0009, 8'h02, 8'h81);
		post(16'hA004, 8'h01, 16'h0009, 8'h02, 8'h41);
		post(16'hA005, 8'h01, 16'h0009, 8'h02, 8'h40);
		post(16'hA006, 8'h01, 16'h0009, 8'h02, 8'h10);
		dispatch_all();
		write_reg(R_ENABLED, 8'd0);
		post(16'hBEEF, 8'h77, 16'h0101, 8'hAA, 8'h55);
		dispatch_all();
		write_reg(R_ENABLED, 8'd1);

		random_phase(80);
		write_reg(R_MODE, 8'd0);
		random_phase(60);
		write_reg(R_MODE, 8'd1);
		write_reg(R_CRIT_MASK, 8'h00);
		write_reg(R_MERGE_MASK, 8'hFF);
		write_reg(R_HIGH_TH, 8'hFF);
		write_reg(R_NORMAL_TH, 8'h00);
		random_phase(60);
		write_reg(R_CRIT_MASK, 8'hFF);
		write_reg(R_MERGE_MASK, 8'h00);
		write_reg(R_HIGH_TH, 8'h00);
		write_reg(R_NORMAL_TH, 8'hFF);
		random_phase(50);
		write_reg(R_CRIT_MASK, 8'($urandom));
		write_reg(R_MERGE_MASK, 8'($urandom));
		write_reg(R_HIGH_TH, 8'($urandom));
		write_reg(R_NORMAL_TH, 8'($urandom));
		write_reg(R_ENABLED, 8'd0);
		random_phase(10);
		write_reg(R_ENABLED, 8'd1);
		random_phase(60);

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== priority_staging_queue_with_merge.f =====
rtl/core/psqm_pkg.sv
rtl/core/psqm_ram.sv
rtl/core/priority_staging_queue_with_merge.sv
verif/priority_staging_queue_with_merge_check.sv
verif/priority_staging_queue_with_merge_test.sv
